// ===== design/iafp_pkg.sv =====
// Package for the IMU angle frame parser: word types, frame record, shared constants.
// Depends on nothing; every other design file but iafp_stream_if uses it by scoped names.
package iafp_pkg;

	localparam int unsigned PAYLOAD_BYTES = 6;
	localparam int unsigned QUEUE_DEPTH   = 2;

	localparam logic [7:0] HDR_FIRST = 8'h55;
	localparam logic [7:0] HDR_ANGLE = 8'h53;

	localparam logic [3:0] POS_HUNT       = 4'd0;
	localparam logic [3:0] POS_HDR        = 4'd1;
	localparam logic [3:0] POS_FIRST_DATA = 4'd2;
	localparam logic [3:0] POS_CHECK      = 4'd10;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_CSUM_ERR = 1'b1;

	typedef struct packed {
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic               status;
		logic signed [15:0] roll_deg_q7;
		logic signed [15:0] pitch_deg_q7;
		logic signed [15:0] yaw_deg_q7;
	} result_t;

	// Completed frame handed from the parser to the converter.
	typedef struct packed {
		logic                           status;
		logic [PAYLOAD_BYTES-1:0][7:0]  payload;
	} frame_t;

endpackage

// ===== design/iafp_stream_if.sv =====
// Valid/ready stream interface used for the byte input and the result output.
// Depends on nothing; the payload type is a parameter.
interface iafp_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== design/imu_angle_frame_parser_core.sv =====
// Top level of the IMU angle frame parser: parser front, frame queue, angle converter.
// Depends on iafp_pkg, iafp_stream_if, iafp_front, iafp_queue and iafp_back.
//
// Takes one serial byte word per cycle and emits one result word per 0x55 0x53 angle
// frame, on its checksum byte: status (ok or checksum mismatch) and roll, pitch and yaw
// in signed Q7 degrees. Input ready stays high at one word per clock; it drops only for
// a checksum byte while the QUEUE_DEPTH-entry frame queue is full, which happens only
// when the result side holds off. After its checksum byte is accepted, a result word is
// registered in a queue entry and then in the output register. Other frame types
// and bytes outside a frame give no result; a rejected frame is not rescanned.
module imu_angle_frame_parser_core #(
	parameter int unsigned QUEUE_DEPTH = iafp_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	iafp_stream_if.sink   in_ch,
	iafp_stream_if.source out_ch
);

	logic             push_valid;
	logic             push_ready;
	iafp_pkg::frame_t push_data;
	logic             pop_valid;
	logic             pop_ready;
	iafp_pkg::frame_t pop_data;

	iafp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	iafp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	iafp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop_ready (pop_ready),
		.out_ch    (out_ch)
	);

endmodule

// ===== design/iafp_front.sv =====
// Front end: header hunt, byte collection and checksum check; pushes one frame record.
// Depends on iafp_pkg and iafp_stream_if.
module iafp_front (
	input  logic              clk,
	input  logic              arst_n,
	iafp_stream_if.sink       in_ch,
	output logic              push_valid,
	output iafp_pkg::frame_t  push_data,
	input  logic              push_ready
);

	logic [3:0] pos_q;
	logic [7:0] sum_q;
	logic [iafp_pkg::PAYLOAD_BYTES-1:0][7:0] payload_q;

	logic [3:0] pos_d;
	logic [7:0] sum_d;
	logic [7:0] rx;
	logic       accept;
	logic       at_check;

	assign rx       = in_ch.data.rx_byte;
	assign at_check = (pos_q == iafp_pkg::POS_CHECK);
	// stall only a checksum word that has nowhere to go
	assign in_ch.ready = !at_check || push_ready;
	assign accept      = in_ch.valid && in_ch.ready;

	assign push_valid        = in_ch.valid && at_check;
	assign push_data.status  = (rx == sum_q) ? iafp_pkg::STATUS_OK : iafp_pkg::STATUS_CSUM_ERR;
	assign push_data.payload = payload_q;

	always_comb begin
		case (pos_q) inside
			iafp_pkg::POS_HDR: begin
				if (rx == iafp_pkg::HDR_ANGLE) begin
					sum_d = sum_q + rx;
					pos_d = iafp_pkg::POS_FIRST_DATA;
				end else if (rx == iafp_pkg::HDR_FIRST) begin
					sum_d = iafp_pkg::HDR_FIRST;
					pos_d = iafp_pkg::POS_HDR;
				end else begin
					sum_d = 8'd0;
					pos_d = iafp_pkg::POS_HUNT;
				end
			end
			[4'd2:4'd9]: begin
				sum_d = sum_q + rx;
				pos_d = pos_q + 4'd1;
			end
			iafp_pkg::POS_CHECK: begin
				sum_d = 8'd0;
				pos_d = iafp_pkg::POS_HUNT;
			end
			default: begin
				if (rx == iafp_pkg::HDR_FIRST) begin
					sum_d = iafp_pkg::HDR_FIRST;
					pos_d = iafp_pkg::POS_HDR;
				end else begin
					sum_d = 8'd0;
					pos_d = iafp_pkg::POS_HUNT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= iafp_pkg::POS_HUNT;
			sum_q <= 8'd0;
		end else if (accept) begin
			pos_q <= pos_d;
			sum_q <= sum_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < iafp_pkg::PAYLOAD_BYTES; i++) begin
			if (accept && pos_q == (iafp_pkg::POS_FIRST_DATA + 4'(i))) begin
				payload_q[i] <= rx;
			end
		end
	end

endmodule

// ===== design/iafp_queue.sv =====
// Short frame queue between parser and converter.
// Depends on iafp_pkg for the frame record type.
module iafp_queue #(
	parameter int unsigned DEPTH = iafp_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	input  iafp_pkg::frame_t  push_data,
	output logic              push_ready,
	output logic              pop_valid,
	output iafp_pkg::frame_t  pop_data,
	input  logic              pop_ready
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	iafp_pkg::frame_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== design/iafp_back.sv =====
// Back end: converts a frame record to Q7 degree angles and holds the result word.
// Depends on iafp_pkg and iafp_stream_if.
module iafp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	input  iafp_pkg::frame_t  pop_data,
	output logic              pop_ready,
	iafp_stream_if.source     out_ch
);

	localparam logic [7:0]  ANGLE_SCALE  = 8'd180;
	localparam logic [15:0] ANGLE_OFFSET = 16'd23040;

	// floor(raw * 180 / 256) through the offset value raw + 32768
	function automatic logic signed [15:0] angle_q7(input logic [7:0] lo, input logic [7:0] hi);
		logic [15:0] biased;
		logic [23:0] prod;
		biased = {~hi[7], hi[6:0], lo};
		prod   = biased * ANGLE_SCALE;
		return $signed(prod[23:8] - ANGLE_OFFSET);
	endfunction

	logic              valid_q;
	iafp_pkg::result_t result_q;
	iafp_pkg::result_t result_d;
	logic              load;

	assign pop_ready = !valid_q || out_ch.ready;
	assign load      = pop_valid && pop_ready;

	always_comb begin
		result_d.status = pop_data.status;
		if (pop_data.status == iafp_pkg::STATUS_OK) begin
			result_d.roll_deg_q7  = angle_q7(pop_data.payload[0], pop_data.payload[1]);
			result_d.pitch_deg_q7 = angle_q7(pop_data.payload[2], pop_data.payload[3]);
			result_d.yaw_deg_q7   = angle_q7(pop_data.payload[4], pop_data.payload[5]);
		end else begin
			result_d.roll_deg_q7  = '0;
			result_d.pitch_deg_q7 = '0;
			result_d.yaw_deg_q7   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop_ready) begin
			valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result_d;
		end
	end

	assign out_ch.valid = valid_q;
	assign out_ch.data  = result_q;

endmodule

// ===== design/iafp_checker.sv =====
// Port-level checks on the result stream of the IMU angle frame parser, bound to the top.
// Depends on iafp_pkg and imu_angle_frame_parser_core.
module iafp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input iafp_pkg::result_t out_data
);

	localparam logic signed [15:0] ANGLE_MIN = -16'sd23040;
	localparam logic signed [15:0] ANGLE_MAX = 16'sd23039;

	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result word changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == iafp_pkg::STATUS_CSUM_ERR |->
			out_data.roll_deg_q7 == 16'sd0 && out_data.pitch_deg_q7 == 16'sd0 &&
			out_data.yaw_deg_q7 == 16'sd0)
		else $error("checksum error word carries nonzero angles");

	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == iafp_pkg::STATUS_OK |->
			out_data.roll_deg_q7 >= ANGLE_MIN && out_data.roll_deg_q7 <= ANGLE_MAX &&
			out_data.pitch_deg_q7 >= ANGLE_MIN && out_data.pitch_deg_q7 <= ANGLE_MAX &&
			out_data.yaw_deg_q7 >= ANGLE_MIN && out_data.yaw_deg_q7 <= ANGLE_MAX)
		else $error("angle outside the Q7 degree range");

endmodule

bind imu_angle_frame_parser_core iafp_checker u_iafp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);
